// File: sv/owm_pkg.sv
// ---------------------------------------------------------------------------
// owm_pkg: shared types and timing for the 1-Wire bus master
// Holds the command codes, sequencer phases, result record and the slot
// timing tables, kept as exact quarter-microsecond counts.
// ---------------------------------------------------------------------------
package owm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int TICKS_PER_US  = 4;

    // Longest phase is the standard reset low time (1920 quarter microseconds)
    localparam int MAX_TICKS = (1920 * TICKS_PER_US + 3) / 4;
    localparam int TMR_W     = $clog2(MAX_TICKS + 1);

    typedef logic [TMR_W-1:0] t_timer;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_RESET = 2'd1,
        FUNC_BYTE  = 2'd2,
        FUNC_BIT   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_WAIT = 3'd1,
        PH_RST_LOW  = 3'd2,
        PH_RST_REL  = 3'd3,
        PH_RST_REC  = 3'd4,
        PH_SLOT_LOW = 3'd5,
        PH_SLOT_REL = 3'd6,
        PH_SLOT_REC = 3'd7
    } t_phase;

    typedef enum logic [3:0] {
        T_A = 4'd0,
        T_B = 4'd1,
        T_C = 4'd2,
        T_D = 4'd3,
        T_E = 4'd4,
        T_F = 4'd5,
        T_G = 4'd6,
        T_H = 4'd7,
        T_I = 4'd8,
        T_J = 4'd9
    } t_tidx;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       presence;
    } t_result;

    // Phase length in ticks: ceil(quarters * TICKS_PER_US / 4)
    function automatic t_timer ticks_of(input logic od, input t_tidx idx);
        logic [10:0] q;
        q = 11'd0;
        if (od) begin
            case (idx)
                T_A: q = 11'd6;
                T_B: q = 11'd30;
                T_C: q = 11'd30;
                T_D: q = 11'd10;
                T_E: q = 11'd3;
                T_F: q = 11'd28;
                T_G: q = 11'd10;
                T_H: q = 11'd280;
                T_I: q = 11'd34;
                T_J: q = 11'd160;
                default: q = 11'd0;
            endcase
        end else begin
            case (idx)
                T_A: q = 11'd24;
                T_B: q = 11'd256;
                T_C: q = 11'd240;
                T_D: q = 11'd40;
                T_E: q = 11'd36;
                T_F: q = 11'd220;
                T_G: q = 11'd0;
                T_H: q = 11'd1920;
                T_I: q = 11'd280;
                T_J: q = 11'd1640;
                default: q = 11'd0;
            endcase
        end
        return t_timer'((int'(q) * TICKS_PER_US + 3) / 4);
    endfunction

endpackage

// File: sv/owm_core.sv
// ---------------------------------------------------------------------------
// owm_core: 1-Wire phase sequencer
// Keeps the phase, slot timer and shift registers, advances them by one tick
// per accepted request and forms the result of that tick.
// ---------------------------------------------------------------------------
module owm_core
    import owm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_overdrive,
    input  t_func      i_func,
    input  logic [7:0] i_tx_data,
    input  logic       i_line_in,
    output t_result    o_result
);

    localparam logic [3:0] BYTE_BITS = 4'(BITS_PER_BYTE);

    t_phase     r_phase,  n_phase;
    t_timer     r_timer,  n_timer;
    logic [3:0] r_bits,   n_bits;
    logic [7:0] r_send,   n_send;
    logic [7:0] r_recv,   n_recv;
    logic       r_pres,   n_pres;
    t_func      r_active, n_active;
    logic       n_done;

    // Next state: one tick of the sequencer
    always_comb begin
        t_phase     tgt;
        logic       go;
        logic       fin;
        t_timer     d;
        logic [3:0] nb;

        n_phase  = r_phase;
        n_timer  = r_timer;
        n_bits   = r_bits;
        n_send   = r_send;
        n_recv   = r_recv;
        n_pres   = r_pres;
        n_active = r_active;
        n_done   = 1'b0;
        tgt      = PH_IDLE;
        go       = 1'b0;
        fin      = 1'b0;
        d        = '0;
        nb       = 4'd1;

        if (r_phase == PH_IDLE) begin
            // Start a command; a plain tick does nothing
            if (i_func != FUNC_TICK) begin
                n_active = i_func;
                go       = 1'b1;
                if (i_func == FUNC_RESET) begin
                    tgt = PH_RST_WAIT;
                end else begin
                    n_send = (i_func == FUNC_BIT) ? {7'd0, i_tx_data[0]} : i_tx_data;
                    n_bits = (i_func == FUNC_BYTE) ? BYTE_BITS : 4'd1;
                    if (n_bits == 4'd0) begin
                        n_bits = 4'd1;
                    end
                    n_recv = 8'd0;
                    tgt    = PH_SLOT_LOW;
                end
            end
        end else if (r_timer != '0) begin
            n_timer = r_timer - t_timer'(1);
        end else begin
            // Phase over: pick its successor
            go = 1'b1;
            unique case (r_phase)
                PH_RST_WAIT: tgt = PH_RST_LOW;
                PH_RST_LOW:  tgt = PH_RST_REL;
                PH_RST_REL:  tgt = PH_RST_REC;
                PH_SLOT_LOW: tgt = r_send[0] ? PH_SLOT_REL : PH_SLOT_REC;
                PH_SLOT_REL: tgt = PH_SLOT_REC;
                PH_SLOT_REC: begin
                    n_send = r_send >> 1;
                    n_bits = (r_bits != 4'd0) ? r_bits - 4'd1 : 4'd0;
                    if (n_bits == 4'd0) begin
                        fin = 1'b1;
                    end else begin
                        tgt = PH_SLOT_LOW;
                    end
                end
                default: fin = 1'b1;
            endcase
        end

        if (fin) begin
            // Finish: right-justify the sampled bits of a touch
            if (n_active == FUNC_BYTE || n_active == FUNC_BIT) begin
                nb     = (n_active == FUNC_BYTE) ? BYTE_BITS : 4'd1;
                n_recv = n_recv >> (4'd8 - nb);
            end
            n_phase = PH_IDLE;
            n_timer = '0;
            n_done  = 1'b1;
        end else if (go) begin
            // Skip the pre-reset wait when its length is zero
            if (tgt == PH_RST_WAIT && ticks_of(i_overdrive, T_G) == '0) begin
                tgt = PH_RST_LOW;
            end
            case (tgt)
                PH_RST_WAIT: d = ticks_of(i_overdrive, T_G);
                PH_RST_LOW:  d = ticks_of(i_overdrive, T_H);
                PH_RST_REL:  d = ticks_of(i_overdrive, T_I);
                PH_RST_REC: begin
                    n_pres = ~i_line_in;
                    d      = ticks_of(i_overdrive, T_J);
                end
                PH_SLOT_LOW: d = ticks_of(i_overdrive, n_send[0] ? T_A : T_C);
                PH_SLOT_REL: d = ticks_of(i_overdrive, T_E);
                PH_SLOT_REC: begin
                    if (n_send[0]) begin
                        n_recv = {i_line_in, n_recv[7:1]};
                        d      = ticks_of(i_overdrive, T_F);
                    end else begin
                        n_recv = n_recv >> 1;
                        d      = ticks_of(i_overdrive, T_D);
                    end
                end
                default: d = t_timer'(1);
            endcase
            n_phase = tgt;
            n_timer = d - t_timer'(1);
        end
    end

    // Outputs: the state after this tick's update
    always_comb begin
        o_result.drive_low = (n_phase == PH_RST_LOW) || (n_phase == PH_SLOT_LOW);
        o_result.busy      = (n_phase != PH_IDLE);
        o_result.done      = n_done;
        o_result.rx_byte   = n_recv;
        o_result.presence  = n_pres;
    end

    // Advance state on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_timer  <= '0;
            r_bits   <= 4'd0;
            r_send   <= 8'd0;
            r_recv   <= 8'd0;
            r_pres   <= 1'b0;
            r_active <= FUNC_TICK;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_bits   <= n_bits;
            r_send   <= n_send;
            r_recv   <= n_recv;
            r_pres   <= n_pres;
            r_active <= n_active;
        end
    end

    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.done |-> r_phase != PH_IDLE)
        else $error("done flagged on a tick that started idle");

    a_timer_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase != PH_IDLE && r_timer != '0 |=> r_timer == $past(r_timer) - t_timer'(1))
        else $error("slot timer did not count down");

    a_slot_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SLOT_LOW || r_phase == PH_SLOT_REL || r_phase == PH_SLOT_REC)
        |-> r_bits != 4'd0)
        else $error("slot running with no bits left");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_timer) && $stable(r_recv))
        else $error("sequencer moved without a tick");

endmodule

// File: sv/onewire_bus_master_slots.sv
// ---------------------------------------------------------------------------
// onewire_bus_master_slots: tick-driven 1-Wire bus master
// Runs bus reset, byte touch and bit touch sequences, one request per tick.
// ---------------------------------------------------------------------------
// Usage:
//   Each input request is one quarter-microsecond tick carrying a command
//   code, the byte to send and the sampled bus level. A command is taken on
//   a tick that finds the master idle; commands arriving while busy are
//   dropped. Every tick yields exactly one result: the drive-low level for
//   the open-drain line, busy and done flags, the receive shift register and
//   the presence flag from the last reset.
//   The result of a tick is presented in the output register on the cycle
//   after it is accepted. Throughput is one tick per cycle while the
//   receiver keeps taking results; the sequencer update sits between the
//   accepted tick and the result register, so a new tick is taken while
//   the previous result is being taken by the receiver.
//   When the receiver stalls, the result holds and input ready drops until
//   the result is taken; no tick is lost and the sequence simply pauses.
//   The overdrive register is written on its own valid/ready channel and is
//   always ready; write it only while the master is idle.
//   Reset clears the sequencer to idle, presence and receive data to zero,
//   overdrive to standard timing, and empties the output register.
// ---------------------------------------------------------------------------
module onewire_bus_master_slots
    import owm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_overdrive,
    // tick request
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_tx_data,
    input  logic       i_line_in,
    // result
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_drive_low,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_presence
);

    logic    r_overdrive;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;
    logic    step;

    // Accept a tick whenever the result register is free or being emptied
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign step        = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Hold the overdrive selection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overdrive <= 1'b0;
        end else if (i_cfg_valid) begin
            r_overdrive <= i_cfg_overdrive;
        end
    end

    owm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_overdrive (r_overdrive),
        .i_func      (t_func'(i_func)),
        .i_tx_data   (i_tx_data),
        .i_line_in   (i_line_in),
        .o_result    (core_res)
    );

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive_low = r_out.drive_low;
    assign o_busy_res  = r_out.busy;
    assign o_done_res  = r_out.done;
    assign o_rx_byte   = r_out.rx_byte;
    assign o_presence  = r_out.presence;

endmodule
